// ===== hw/rtl/cbmi_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with IRQ counter.
// No dependencies; used by cbmi_map and cartridge_bank_mapper_irq_core.
`timescale 1ns / 1ps
`default_nettype none

package cbmi_pkg;

    // default bank counts of the attached ROMs
    localparam int PRG_BANKS_DEF = 64;
    localparam int CHR_BANKS_DEF = 256;

    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int TGT_W      = 3;
    localparam int IDX_W      = 19;
    localparam int PRG_BANK_W = 6;
    localparam int CHR_BANK_W = 8;
    localparam int COUNT_W    = 15;
    localparam int NUM_SLOTS  = 3;
    localparam int NUM_WIN    = 12;

    // bus commands
    localparam logic [CMD_W-1:0] CMD_CPU_RD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CPU_WR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PPU_RD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PPU_WR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    // result targets
    localparam logic [TGT_W-1:0] TGT_NONE  = 3'd0;
    localparam logic [TGT_W-1:0] TGT_REG   = 3'd1;
    localparam logic [TGT_W-1:0] TGT_PRG   = 3'd2;
    localparam logic [TGT_W-1:0] TGT_RAM   = 3'd3;
    localparam logic [TGT_W-1:0] TGT_CHR   = 3'd4;
    localparam logic [TGT_W-1:0] TGT_NTRAM = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] bus_addr;
        logic [DATA_W-1:0] wr_data;
    } item_t;

    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [IDX_W-1:0]  mem_index;
        logic              mem_write;
        logic [DATA_W-1:0] read_byte;
        logic              irq_line;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cartridge_bank_mapper_irq_core.sv =====
// Top level of the cartridge bank mapper: stream ports, input stage and result register.
// Depends on cbmi_pkg and cbmi_map.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                                          tuser
// s_axis    in   [15:0] bus_addr, [23:16] wr_data               [2:0] cmd
// m_axis    out  [18:0] mem_index, [19] mem_write,              [2:0] target
//                [27:20] read_byte, [28] irq_line, [31:29] zero
//
// One word per cycle while m_axis_tready stays high; m_axis_tvalid is registered.
// The decode, bank lookup and counter update sit between the input stage register
// and the result register, and mapper state is committed as a word moves across.
// rst_n clears the valid flags and all mapper state (banks, windows, IRQ counter).
// A stalled result holds in the output register; an empty input stage takes one more
// word, then s_axis_tready stays low until m_axis_tready returns.

module cartridge_bank_mapper_irq_core #(
    parameter int PRG_BANKS = cbmi_pkg::PRG_BANKS_DEF,
    parameter int CHR_BANKS = cbmi_pkg::CHR_BANKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] bus_addr, [23:16] wr_data
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [18:0] mem_index, [19] mem_write,
                                             // [27:20] read_byte, [28] irq_line
    output logic [2:0]       m_axis_tuser    // [2:0] target
);

    logic              in_valid_reg, in_valid_next;
    cbmi_pkg::item_t   in_item_reg;
    logic              out_valid_reg, out_valid_next;
    cbmi_pkg::result_t out_result_reg;
    cbmi_pkg::result_t result;
    logic              accept;
    logic              advance;

    // a word moves into the result register when there is room there
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
    end

    cbmi_map #(
        .PRG_BANKS (PRG_BANKS),
        .CHR_BANKS (CHR_BANKS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.cmd      <= s_axis_tuser;
            in_item_reg.bus_addr <= s_axis_tdata[15:0];
            in_item_reg.wr_data  <= s_axis_tdata[23:16];
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.target;
    assign m_axis_tdata  = {3'b000,
                            out_result_reg.irq_line,
                            out_result_reg.read_byte,
                            out_result_reg.mem_write,
                            out_result_reg.mem_index};

`ifndef NO_ASSERTIONS
    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input stage word dropped");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost on transfer");

    a_index_zero_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_result_reg.target == cbmi_pkg::TGT_NONE ||
                          out_result_reg.target == cbmi_pkg::TGT_REG)
        |-> out_result_reg.mem_index == '0 && !out_result_reg.mem_write)
        else $error("memory index or write on non-memory result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cbmi_map.sv =====
// Mapper state (banks, windows, IRQ counter) and the combinational decode of one word.
// Depends on cbmi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbmi_map #(
    parameter int PRG_BANKS = cbmi_pkg::PRG_BANKS_DEF,
    parameter int CHR_BANKS = cbmi_pkg::CHR_BANKS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,     // commit this word's state effects
    input  wire cbmi_pkg::item_t  item,
    output cbmi_pkg::result_t     result
);

    localparam logic [1:0] SRC_CHR   = 2'd0;
    localparam logic [1:0] SRC_NT_LO = 2'd1;
    localparam logic [1:0] SRC_NT_HI = 2'd2;
    localparam logic [1:0] SRC_NONE  = 2'd3;

    localparam int PRG_ENTRIES = 2 ** cbmi_pkg::PRG_BANK_W;
    localparam int CHR_ENTRIES = 2 ** cbmi_pkg::CHR_BANK_W;
    localparam logic [cbmi_pkg::COUNT_W-1:0] COUNT_MAX = 15'h7FFF;
    localparam logic [cbmi_pkg::DATA_W-1:0]  NT_SELECT = 8'hE0;

    // bank number modulo ROM size, folded at elaboration
    logic [cbmi_pkg::PRG_BANK_W-1:0] prg_mod [PRG_ENTRIES];
    logic [cbmi_pkg::CHR_BANK_W-1:0] chr_mod [CHR_ENTRIES];

    for (genvar i = 0; i < PRG_ENTRIES; i++) begin : g_prg_mod
        assign prg_mod[i] = cbmi_pkg::PRG_BANK_W'(i % PRG_BANKS);
    end
    for (genvar i = 0; i < CHR_ENTRIES; i++) begin : g_chr_mod
        assign chr_mod[i] = cbmi_pkg::CHR_BANK_W'(i % CHR_BANKS);
    end

    logic [cbmi_pkg::COUNT_W-1:0]    irq_count_reg, irq_count_next;
    logic                            irq_enable_reg, irq_enable_next;
    logic                            irq_pending_reg, irq_pending_next;
    logic                            nt_low_ok_reg, nt_low_ok_next;
    logic                            nt_high_ok_reg, nt_high_ok_next;
    logic [cbmi_pkg::PRG_BANK_W-1:0] prg_bank_reg [cbmi_pkg::NUM_SLOTS];
    logic [cbmi_pkg::PRG_BANK_W-1:0] prg_bank_next [cbmi_pkg::NUM_SLOTS];
    logic [cbmi_pkg::CHR_BANK_W-1:0] chr_bank_reg [cbmi_pkg::NUM_WIN];
    logic [cbmi_pkg::CHR_BANK_W-1:0] chr_bank_next [cbmi_pkg::NUM_WIN];
    logic [1:0]                      win_src_reg [cbmi_pkg::NUM_WIN];
    logic [1:0]                      win_src_next [cbmi_pkg::NUM_WIN];

    logic [cbmi_pkg::ADDR_W-1:0]     a;
    logic [cbmi_pkg::DATA_W-1:0]     d;
    logic [3:0]                      cpu_win;
    logic [3:0]                      ppu_win;
    logic                            ppu_in;
    logic                            win_ok;
    logic [1:0]                      src;
    logic [cbmi_pkg::PRG_BANK_W-1:0] prg_sel;

    assign a       = item.bus_addr;
    assign d       = item.wr_data;
    assign cpu_win = a[14:11];
    assign ppu_win = a[13:10];
    assign ppu_in  = (a < 16'h3000);
    assign src     = ppu_in ? win_src_reg[ppu_win] : SRC_NONE;
    assign win_ok  = (cpu_win < 4'd4) ? nt_low_ok_reg
                   : (cpu_win < 4'd8) ? nt_high_ok_reg : 1'b1;

    always_comb
    begin
        case (a[14:13])
            2'd0:    prg_sel = prg_bank_reg[0];
            2'd1:    prg_sel = prg_bank_reg[1];
            2'd2:    prg_sel = prg_bank_reg[2];
            default: prg_sel = cbmi_pkg::PRG_BANK_W'(PRG_BANKS - 1);
        endcase
    end

    always_comb
    begin
        irq_count_next   = irq_count_reg;
        irq_enable_next  = irq_enable_reg;
        irq_pending_next = irq_pending_reg;
        nt_low_ok_next   = nt_low_ok_reg;
        nt_high_ok_next  = nt_high_ok_reg;
        prg_bank_next    = prg_bank_reg;
        chr_bank_next    = chr_bank_reg;
        win_src_next     = win_src_reg;

        result.target    = cbmi_pkg::TGT_NONE;
        result.mem_index = '0;
        result.mem_write = 1'b0;
        result.read_byte = '0;

        case (item.cmd)
            cbmi_pkg::CMD_CPU_RD:
            begin
                if (a inside {[16'h5000:16'h57FF]})
                begin
                    result.target    = cbmi_pkg::TGT_REG;
                    result.read_byte = irq_count_reg[7:0];
                end
                else if (a inside {[16'h5800:16'h5FFF]})
                begin
                    result.target    = cbmi_pkg::TGT_REG;
                    result.read_byte = {irq_enable_reg, irq_count_reg[14:8]};
                end
                else if (a inside {[16'h6000:16'h7FFF]})
                begin
                    result.target    = cbmi_pkg::TGT_RAM;
                    result.mem_index = cbmi_pkg::IDX_W'(a[12:0]);
                end
                else if (a[15])
                begin
                    result.target    = cbmi_pkg::TGT_PRG;
                    result.mem_index = {prg_mod[prg_sel], a[12:0]};
                end
            end
            cbmi_pkg::CMD_CPU_WR:
            begin
                result.target = cbmi_pkg::TGT_REG;
                if (a inside {[16'h5000:16'h57FF]})
                begin
                    irq_count_next   = {irq_count_reg[14:8], d};
                    irq_pending_next = 1'b0;
                end
                else if (a inside {[16'h5800:16'h5FFF]})
                begin
                    irq_count_next   = {d[6:0], irq_count_reg[7:0]};
                    irq_enable_next  = d[7];
                    irq_pending_next = 1'b0;
                end
                else if (a inside {[16'h6000:16'h7FFF]})
                begin
                    result.target    = cbmi_pkg::TGT_RAM;
                    result.mem_index = cbmi_pkg::IDX_W'(a[12:0]);
                    result.mem_write = 1'b1;
                end
                else if (a inside {[16'h8000:16'hDFFF]})
                begin
                    // window index is 0..11 over this range
                    if (d >= NT_SELECT && win_ok)
                    begin
                        win_src_next[cpu_win] = d[0] ? SRC_NT_HI : SRC_NT_LO;
                    end
                    else
                    begin
                        win_src_next[cpu_win]  = SRC_CHR;
                        chr_bank_next[cpu_win] = d;
                    end
                end
                else if (a inside {[16'hE000:16'hE7FF]})
                begin
                    prg_bank_next[0] = d[5:0];
                end
                else if (a inside {[16'hE800:16'hEFFF]})
                begin
                    prg_bank_next[1] = d[5:0];
                    nt_high_ok_next  = ~d[6];
                    nt_low_ok_next   = ~d[7];
                end
                else if (a inside {[16'hF000:16'hF7FF]})
                begin
                    prg_bank_next[2] = d[5:0];
                end
                else
                begin
                    result.target = cbmi_pkg::TGT_NONE;
                end
            end
            cbmi_pkg::CMD_PPU_RD, cbmi_pkg::CMD_PPU_WR:
            begin
                case (src)
                    SRC_CHR:
                    begin
                        if (item.cmd == cbmi_pkg::CMD_PPU_RD)
                        begin
                            result.target    = cbmi_pkg::TGT_CHR;
                            result.mem_index = cbmi_pkg::IDX_W'(
                                {chr_mod[chr_bank_reg[ppu_win]], a[9:0]});
                        end
                    end
                    SRC_NT_LO, SRC_NT_HI:
                    begin
                        result.target    = cbmi_pkg::TGT_NTRAM;
                        result.mem_index = cbmi_pkg::IDX_W'({src == SRC_NT_HI, a[9:0]});
                        result.mem_write = (item.cmd == cbmi_pkg::CMD_PPU_WR);
                    end
                    default:
                    begin
                        if (item.cmd == cbmi_pkg::CMD_PPU_RD)
                        begin
                            result.read_byte = 8'hFF;
                        end
                    end
                endcase
            end
            cbmi_pkg::CMD_TICK:
            begin
                if (irq_enable_reg)
                begin
                    if (irq_count_reg == COUNT_MAX)
                    begin
                        irq_pending_next = 1'b1;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg + 15'd1;
                    end
                end
            end
            default:
            begin
                result.target = cbmi_pkg::TGT_NONE;
            end
        endcase

        result.irq_line = irq_pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_count_reg   <= '0;
            irq_enable_reg  <= 1'b0;
            irq_pending_reg <= 1'b0;
            nt_low_ok_reg   <= 1'b0;
            nt_high_ok_reg  <= 1'b0;
            for (int i = 0; i < cbmi_pkg::NUM_SLOTS; i++)
            begin
                prg_bank_reg[i] <= '0;
            end
            for (int i = 0; i < cbmi_pkg::NUM_WIN; i++)
            begin
                chr_bank_reg[i] <= '0;
                win_src_reg[i]  <= SRC_CHR;
            end
        end
        else if (step)
        begin
            irq_count_reg   <= irq_count_next;
            irq_enable_reg  <= irq_enable_next;
            irq_pending_reg <= irq_pending_next;
            nt_low_ok_reg   <= nt_low_ok_next;
            nt_high_ok_reg  <= nt_high_ok_next;
            prg_bank_reg    <= prg_bank_next;
            chr_bank_reg    <= chr_bank_next;
            win_src_reg     <= win_src_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pending_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_pending_reg) |->
            $past(step && item.cmd == cbmi_pkg::CMD_TICK && irq_enable_reg))
        else $error("irq pending raised without an enabled tick");

    a_counter_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.cmd == cbmi_pkg::CMD_CPU_WR && a[15:12] == 4'h5 |=> !irq_pending_reg)
        else $error("counter write left irq pending");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(irq_count_reg) && $stable(irq_pending_reg))
        else $error("irq state changed without a word");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for cartridge_bank_mapper_irq_core: directed table, then random bus traffic.
// Depends on cbmi_pkg and the core RTL; expected words come from a local mapper predictor.
`timescale 1ns / 1ps

module testbench;

    // command outside the defined set, and the window source codes of the predictor
    localparam logic [cbmi_pkg::CMD_W-1:0] CMD_UNDEF = 3'd7;
    localparam logic [1:0] SRC_CHR   = 2'd0;
    localparam logic [1:0] SRC_NT_LO = 2'd1;
    localparam logic [1:0] SRC_NT_HI = 2'd2;
    localparam logic [1:0] SRC_OPEN  = 2'd3;

    localparam int RANDOM_WORDS = 420;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [15:0] bus_addr, [23:16] wr_data
    logic [2:0]  s_axis_tuser = '0;     // [2:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [18:0] mem_index, [19] mem_write,
                                        // [27:20] read_byte, [28] irq_line
    logic [2:0]  m_axis_tuser;          // [2:0] target

    cartridge_bank_mapper_irq_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Mapper predictor state: mirrors what the core should hold
    // ------------------------------------------------------------------
    logic [cbmi_pkg::COUNT_W-1:0]    irq_count;
    logic                            irq_enable;
    logic                            irq_pending;
    logic [cbmi_pkg::PRG_BANK_W-1:0] prg_bank [cbmi_pkg::NUM_SLOTS];
    logic [cbmi_pkg::CHR_BANK_W-1:0] chr_bank [cbmi_pkg::NUM_WIN];
    logic [1:0]                      win_src  [cbmi_pkg::NUM_WIN];
    logic                            nt_low_ok;
    logic                            nt_high_ok;

    cbmi_pkg::result_t mapping_q [$];     // expected words, oldest first
    int errors      = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int irq_raises  = 0;
    int nt_selects  = 0;
    int cycles      = 0;
    int stall_left  = 0;
    logic steady    = 1'b0;     // no idling on either side while set

    function automatic void clear_mapper();
        irq_count   = '0;
        irq_enable  = 1'b0;
        irq_pending = 1'b0;
        nt_low_ok   = 1'b0;
        nt_high_ok  = 1'b0;
        for (int i = 0; i < cbmi_pkg::NUM_SLOTS; i++)
            prg_bank[i] = '0;
        for (int i = 0; i < cbmi_pkg::NUM_WIN; i++)
        begin
            chr_bank[i] = '0;
            win_src[i]  = SRC_CHR;
        end
    endfunction

    // Decode one bus word, commit its effect on the mapper state, return the result word.
    function automatic cbmi_pkg::result_t map_access(input cbmi_pkg::item_t it);
        cbmi_pkg::result_t r;
        logic [15:0] a;
        logic [7:0]  d;
        int          w;
        int          slot;
        int          bank;
        logic        ok;
        logic [1:0]  src;
        r = '0;
        a = it.bus_addr;
        d = it.wr_data;
        r.target = cbmi_pkg::TGT_NONE;
        case (it.cmd)
            cbmi_pkg::CMD_CPU_RD:
            begin
                if (a >= 16'h5000 && a <= 16'h57FF)
                begin
                    r.target    = cbmi_pkg::TGT_REG;
                    r.read_byte = irq_count[7:0];
                end
                else if (a >= 16'h5800 && a <= 16'h5FFF)
                begin
                    r.target    = cbmi_pkg::TGT_REG;
                    r.read_byte = {irq_enable, irq_count[14:8]};
                end
                else if (a >= 16'h6000 && a <= 16'h7FFF)
                begin
                    r.target    = cbmi_pkg::TGT_RAM;
                    r.mem_index = cbmi_pkg::IDX_W'(a - 16'h6000);
                end
                else if (a >= 16'h8000)
                begin
                    slot = int'((a - 16'h8000) >> 13);
                    bank = (slot < cbmi_pkg::NUM_SLOTS) ? int'(prg_bank[slot])
                                                        : cbmi_pkg::PRG_BANKS_DEF - 1;
                    bank = bank % cbmi_pkg::PRG_BANKS_DEF;
                    r.target    = cbmi_pkg::TGT_PRG;
                    r.mem_index = cbmi_pkg::IDX_W'(bank * 32'h2000 + a[12:0]);
                end
            end
            cbmi_pkg::CMD_CPU_WR:
            begin
                r.target = cbmi_pkg::TGT_REG;
                if (a >= 16'h6000 && a <= 16'h7FFF)
                begin
                    r.target    = cbmi_pkg::TGT_RAM;
                    r.mem_index = cbmi_pkg::IDX_W'(a - 16'h6000);
                    r.mem_write = 1'b1;
                end
                else if (a >= 16'h5000 && a <= 16'h57FF)
                begin
                    irq_count[7:0] = d;
                    irq_pending    = 1'b0;
                end
                else if (a >= 16'h5800 && a <= 16'h5FFF)
                begin
                    irq_count[14:8] = d[6:0];
                    irq_enable      = d[7];
                    irq_pending     = 1'b0;
                end
                else if (a >= 16'h8000 && a <= 16'hDFFF)
                begin
                    w  = int'((a - 16'h8000) >> 11);
                    ok = (w < 4) ? nt_low_ok : (w < 8) ? nt_high_ok : 1'b1;
                    if (d >= 8'hE0 && ok)
                    begin
                        win_src[w] = d[0] ? SRC_NT_HI : SRC_NT_LO;
                        nt_selects++;
                    end
                    else
                    begin
                        win_src[w]  = SRC_CHR;
                        chr_bank[w] = d;
                    end
                end
                else if (a >= 16'hE000 && a <= 16'hE7FF)
                    prg_bank[0] = d[5:0];
                else if (a >= 16'hE800 && a <= 16'hEFFF)
                begin
                    prg_bank[1] = d[5:0];
                    nt_high_ok  = ~d[6];
                    nt_low_ok   = ~d[7];
                end
                else if (a >= 16'hF000 && a <= 16'hF7FF)
                    prg_bank[2] = d[5:0];
                else
                    r.target = cbmi_pkg::TGT_NONE;  // chip RAM port, write protect, unmapped
            end
            cbmi_pkg::CMD_PPU_RD, cbmi_pkg::CMD_PPU_WR:
            begin
                if (a < 16'h3000)
                begin
                    w   = int'(a[13:10]);
                    src = (w < cbmi_pkg::NUM_WIN) ? win_src[w] : SRC_OPEN;
                    if (src == SRC_CHR)
                    begin
                        // pattern writes to ROM are dropped
                        if (it.cmd == cbmi_pkg::CMD_PPU_RD)
                        begin
                            r.target    = cbmi_pkg::TGT_CHR;
                            r.mem_index = cbmi_pkg::IDX_W'(
                                (chr_bank[w] % cbmi_pkg::CHR_BANKS_DEF) * 32'h400 + a[9:0]);
                        end
                    end
                    else if (src == SRC_NT_LO || src == SRC_NT_HI)
                    begin
                        r.target    = cbmi_pkg::TGT_NTRAM;
                        r.mem_index = cbmi_pkg::IDX_W'(
                            a[9:0] + ((src == SRC_NT_HI) ? 32'h400 : 32'h0));
                        r.mem_write = (it.cmd == cbmi_pkg::CMD_PPU_WR);
                    end
                    else if (it.cmd == cbmi_pkg::CMD_PPU_RD)
                        r.read_byte = 8'hFF;
                end
                else if (it.cmd == cbmi_pkg::CMD_PPU_RD)
                    r.read_byte = 8'hFF;        // open bus above the pattern/name area
            end
            cbmi_pkg::CMD_TICK:
            begin
                if (irq_enable)
                begin
                    if (irq_count == 15'h7FFF)
                    begin
                        if (!irq_pending)
                            irq_raises++;
                        irq_pending = 1'b1;
                    end
                    else
                        irq_count = irq_count + 1'b1;
                end
            end
            default: ;
        endcase
        r.irq_line = irq_pending;
        return r;
    endfunction

    function automatic cbmi_pkg::result_t make_result(
        input logic [cbmi_pkg::TGT_W-1:0] tgt, input int idx,
        input logic wr, input logic [7:0] rb);
        cbmi_pkg::result_t r;
        r.target    = tgt;
        r.mem_index = cbmi_pkg::IDX_W'(idx);
        r.mem_write = wr;
        r.read_byte = rb;
        r.irq_line  = 1'b0;
        return r;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 50)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch word %0d: %s got 0x%0h want 0x%0h", words_seen, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and field-by-field comparison
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        if (stall_left > 0)
            m_axis_tready <= 1'b0;
        else if (steady || $urandom_range(0, 9) < 7)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        cbmi_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (mapping_q.size() == 0)
                report_mismatch("word with nothing expected, tdata", m_axis_tdata, 0);
            else
            begin
                want = mapping_q.pop_front();
                if (m_axis_tuser != want.target)
                    report_mismatch("target", m_axis_tuser, want.target);
                if (m_axis_tdata[18:0] != want.mem_index)
                    report_mismatch("mem_index", m_axis_tdata[18:0], want.mem_index);
                if (m_axis_tdata[19] != want.mem_write)
                    report_mismatch("mem_write", m_axis_tdata[19], want.mem_write);
                if (m_axis_tdata[27:20] != want.read_byte)
                    report_mismatch("read_byte", m_axis_tdata[27:20], want.read_byte);
                if (m_axis_tdata[28] != want.irq_line)
                    report_mismatch("irq_line", m_axis_tdata[28], want.irq_line);
                if (m_axis_tdata[31:29] != 3'b000)
                    report_mismatch("tdata pad", m_axis_tdata[31:29], 0);
            end
            words_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, mapping_q.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------
    typedef struct {
        cbmi_pkg::item_t   it;
        logic              typed;     // expected word written into the table
        cbmi_pkg::result_t want;
    } plan_row_t;

    plan_row_t plan [$];

    function automatic void add_typed(input logic [2:0] cmd, input logic [15:0] a,
                                      input logic [7:0] d,
                                      input logic [cbmi_pkg::TGT_W-1:0] tgt,
                                      input int idx, input logic wr, input logic [7:0] rb);
        plan_row_t row;
        row.it    = '{cmd: cmd, bus_addr: a, wr_data: d};
        row.typed = 1'b1;
        row.want  = make_result(tgt, idx, wr, rb);
        plan.push_back(row);
    endfunction

    function automatic void add_pred(input logic [2:0] cmd, input logic [15:0] a,
                                     input logic [7:0] d);
        plan_row_t row;
        row.it    = '{cmd: cmd, bus_addr: a, wr_data: d};
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    // Offer one word, hold it until taken, then queue what it should produce.
    // tvalid gets one nonblocking write per time step: lowered only for a real gap.
    task automatic send_word(input cbmi_pkg::item_t it, input logic typed,
                             input cbmi_pkg::result_t want);
        int                gap;
        cbmi_pkg::result_t pred;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.wr_data, it.bus_addr};
        s_axis_tuser  <= it.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = map_access(it);
        mapping_q.push_back(typed ? want : pred);
        words_sent++;
    endtask

    task automatic send_bus(input logic [2:0] cmd, input logic [15:0] a, input logic [7:0] d);
        send_word('{cmd: cmd, bus_addr: a, wr_data: d}, 1'b0, '0);
    endtask

    // Sender holds off until every expected word has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (mapping_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int kind;
        int random_sent;
        logic [7:0] lo;

        clear_mapper();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows: state just after reset, address extremes,
        // unmapped and ignored cases. The rest are left to the predictor.
        add_typed(cbmi_pkg::CMD_CPU_RD, 16'h5000, 8'h00, cbmi_pkg::TGT_REG, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_RD, 16'h5FFF, 8'h00, cbmi_pkg::TGT_REG, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_RD, 16'hE000, 8'h00, cbmi_pkg::TGT_PRG, 'h7E000, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_RD, 16'hFFFF, 8'h00, cbmi_pkg::TGT_PRG, 'h7FFFF, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_RD, 16'h0000, 8'h00, cbmi_pkg::TGT_NONE, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_WR, 16'h6000, 8'hFF, cbmi_pkg::TGT_RAM, 0, 1'b1, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_RD, 16'h7FFF, 8'h00, cbmi_pkg::TGT_RAM, 'h1FFF, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_PPU_RD, 16'h0000, 8'h00, cbmi_pkg::TGT_CHR, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_PPU_WR, 16'h03FF, 8'h55, cbmi_pkg::TGT_NONE, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_PPU_RD, 16'h3000, 8'h00, cbmi_pkg::TGT_NONE, 0, 1'b0, 8'hFF);
        add_typed(CMD_UNDEF,            16'hFFFF, 8'hFF, cbmi_pkg::TGT_NONE, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_CPU_WR, 16'hF800, 8'hAA, cbmi_pkg::TGT_NONE, 0, 1'b0, 8'h00);
        add_typed(cbmi_pkg::CMD_TICK,   16'h0000, 8'h00, cbmi_pkg::TGT_NONE, 0, 1'b0, 8'h00);
        // banks, window selects (ntram allowed via 0xE800 bits 6/7 clear)
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'hE000, 8'hFF);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'hE800, 8'h3F);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'hF7FF, 8'h2A);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'h8000, 8'hE0);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'hA7FF, 8'hE1);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'hDFFF, 8'hFF);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'h8800, 8'hDF);
        add_pred(cbmi_pkg::CMD_PPU_WR, 16'h0001, 8'hA5);
        add_pred(cbmi_pkg::CMD_PPU_RD, 16'h2FFF, 8'h00);
        add_pred(cbmi_pkg::CMD_CPU_RD, 16'hC000, 8'h00);
        // counter one short of the top, enabled: tick to the top, raise, read back, clear
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'h5000, 8'hFE);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'h5800, 8'hFF);
        add_pred(cbmi_pkg::CMD_TICK,   16'h0000, 8'h00);
        add_pred(cbmi_pkg::CMD_TICK,   16'h0000, 8'h00);
        add_pred(cbmi_pkg::CMD_CPU_RD, 16'h5800, 8'h00);
        add_pred(cbmi_pkg::CMD_CPU_WR, 16'h5000, 8'h00);

        foreach (plan[i])
            send_word(plan[i].it, plan[i].typed, plan[i].want);
        wait_drained();

        // Random part: mostly well-formed set-up-then-use sequences, some noise.
        random_sent = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            kind   = $urandom_range(0, 9);
            n      = words_sent;
            if (kind < 2)
            begin
                // arm the counter near the top and tick it, sometimes past the top
                lo = 8'(8'hFF - $urandom_range(0, 12));
                if ($urandom_range(0, 1))
                begin
                    send_bus(cbmi_pkg::CMD_CPU_WR,
                             16'(16'h5000 + $urandom_range(0, 16'h7FF)), lo);
                    send_bus(cbmi_pkg::CMD_CPU_WR,
                             16'(16'h5800 + $urandom_range(0, 16'h7FF)),
                             8'(($urandom_range(0, 4) != 0) ? 8'hFF : $urandom_range(0, 255)));
                end
                else
                begin
                    send_bus(cbmi_pkg::CMD_CPU_WR,
                             16'(16'h5800 + $urandom_range(0, 16'h7FF)),
                             8'(($urandom_range(0, 4) != 0) ? 8'hFF : $urandom_range(0, 255)));
                    send_bus(cbmi_pkg::CMD_CPU_WR,
                             16'(16'h5000 + $urandom_range(0, 16'h7FF)), lo);
                end
                repeat ($urandom_range(1, 18))
                    send_bus(cbmi_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
                send_bus(cbmi_pkg::CMD_CPU_RD, 16'(16'h5000 + $urandom_range(0, 16'hFFF)),
                         8'($urandom));
            end
            else if (kind < 5)
            begin
                // window set-up, then pattern/nametable traffic
                send_bus(cbmi_pkg::CMD_CPU_WR, 16'(16'hE800 + $urandom_range(0, 16'h7FF)),
                         8'($urandom));
                repeat ($urandom_range(1, 4))
                    send_bus(cbmi_pkg::CMD_CPU_WR,
                             16'(16'h8000 + 16'h800 * $urandom_range(0, 11)
                                 + $urandom_range(0, 16'h7FF)),
                             8'($urandom_range(0, 1) ? $urandom_range(8'hE0, 8'hFF)
                                                     : $urandom_range(0, 255)));
                repeat ($urandom_range(3, 8))
                    send_bus($urandom_range(0, 1) ? cbmi_pkg::CMD_PPU_RD : cbmi_pkg::CMD_PPU_WR,
                             16'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 16'h2FFF)
                                                             : $urandom),
                             8'($urandom));
            end
            else if (kind < 7)
            begin
                // PRG bank switching, then CPU reads over the whole upper map
                repeat ($urandom_range(1, 3))
                    send_bus(cbmi_pkg::CMD_CPU_WR,
                             16'(16'hE000 + 16'h800 * $urandom_range(0, 2)
                                 + $urandom_range(0, 16'h7FF)),
                             8'($urandom));
                repeat ($urandom_range(3, 6))
                    send_bus(cbmi_pkg::CMD_CPU_RD,
                             16'(($urandom_range(0, 4) != 0)
                                 ? $urandom_range(16'h8000, 16'hFFFF)
                                 : $urandom_range(16'h5000, 16'h7FFF)),
                             8'($urandom));
            end
            else
            begin
                // anything at all, undefined commands included
                repeat ($urandom_range(1, 5))
                    send_bus(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
            end
            random_sent += words_sent - n;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        steady = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d words (%0d from the table), %0d IRQ raises, %0d ntram selects",
                 words_sent, plan.size(), irq_raises, nt_selects);
        $display("%0d words checked, %0d mismatches, %0d still expected",
                 words_seen, errors, mapping_q.size());
        if (errors == 0 && mapping_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
